@@ rtl/tccc_pkg.sv @@
// Shared types, constants and register codes for the three coil odd coupling controller.
// Used by the lane, merge, top level and bench files; depends on nothing.
`default_nettype none
package tccc_pkg;

    localparam int TABLE_DEPTH = 2048;

    localparam int PROD_W = 46;                    // width * 1e9 fits in 46 bits
    localparam int DUTY_W = 30;
    localparam logic [DUTY_W-1:0] PPB_FULL = 30'd1000000000;

    // floor(x/1000) == (x * GAIN_RECIP) >> RECIP_SHIFT for x below 2^21
    localparam int RECIP_SHIFT = 32;
    localparam logic [22:0] GAIN_RECIP = 23'd4294968;
    localparam logic [28:0] SAT_MAG = 29'd2049000;  // 2049 * 1000
    localparam logic [11:0] DRIVE_CAP = 12'd2048;

    typedef enum logic [2:0] {
        REG_GAIN     = 3'd0,
        REG_LIMIT    = 3'd1,
        REG_WIN_LOW  = 3'd2,
        REG_WIN_HIGH = 3'd3,
        REG_STEP     = 3'd4,
        REG_CENTER_A = 3'd5,
        REG_CENTER_B = 3'd6,
        REG_CENTER_C = 3'd7
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_TABLE_WRITE = 1'b0,
        OP_SAMPLE      = 1'b1
    } op_code_t;

    typedef struct packed {
        logic [DUTY_W-1:0] lo;
        logic [DUTY_W-1:0] hi;
        logic [DUTY_W-1:0] step;
    } duty_cfg_t;

    typedef enum logic [2:0] {
        L_IDLE, L_MUL, L_DIV1, L_CLAMP, L_DIV2, L_DONE
    } lane_state_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LANE, ST_RD_A, ST_RD_B, ST_RD_C, ST_MSTART, ST_MWAIT, ST_EMIT
    } top_state_t;

endpackage
`default_nettype wire

@@ rtl/three_coil_odd_coupling_controller_unit.sv @@
// Top level: APB registers, input holding stage, three duty lanes, displacement table,
// merge stage and output register. Depends on tccc_pkg, tccc_lane and tccc_merge.
//
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | s_tdata (8 fields), s_tuser (op)
//  m_      | out | m_tvalid / m_tready    | m_tdata (3 drives, 3 positions)
//  apb     | in  | psel / penable / pready| paddr, pwdata, prdata
//
// A control sample holds the sequencer through a start state, the lanes'
// bit-serial dividers (load, 46 quotient steps for the duty, a clamp step, 30 steps
// for the table index, done), 3 table reads, a merge start, 3 merge stages and the
// emit state. A table write is done as it leaves the holding stage. One item waits
// in the holding stage while the previous one runs; the emit state stalls while the
// output register still holds an unaccepted beat. Reset is synchronous and clears
// control state and the configuration registers; the table holds nothing defined
// until written.
`default_nettype none
module three_coil_odd_coupling_controller_unit #(
    parameter int TABLE_DEPTH = tccc_pkg::TABLE_DEPTH
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // entry_index[10:0] entry_value[26:11] width_a[42:27] period_a[58:43]
    // width_b[74:59] period_b[90:75] width_c[106:91] period_c[122:107]
    input  wire  [127:0] s_tdata,
    input  wire  [0:0]   s_tuser,   // op[0]
    output logic         m_tvalid,
    input  wire          m_tready,
    // drive_a[12:0] drive_b[25:13] drive_c[38:26] position_a[55:39]
    // position_b[72:56] position_c[89:73]
    output logic [95:0]  m_tdata,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int AW = $clog2(TABLE_DEPTH);

    // configuration
    logic signed [10:0] gain_reg;
    logic [11:0]        limit_reg;
    logic [29:0]        lo_reg, hi_reg, step_reg;
    logic signed [15:0] ctr_a_reg, ctr_b_reg, ctr_c_reg;
    tccc_pkg::reg_idx_t ridx;
    tccc_pkg::duty_cfg_t dcfg;

    assign pready = 1'b1;
    assign ridx   = tccc_pkg::reg_idx_t'(paddr[4:2]);
    assign dcfg   = '{lo: lo_reg, hi: hi_reg, step: step_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= '0;
            limit_reg <= 12'd1843;
            lo_reg    <= 30'd170000000;
            hi_reg    <= 30'd470000000;
            step_reg  <= 30'd146484;
            ctr_a_reg <= '0;
            ctr_b_reg <= '0;
            ctr_c_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (ridx)
                tccc_pkg::REG_GAIN:     gain_reg  <= pwdata[10:0];
                tccc_pkg::REG_LIMIT:    limit_reg <= pwdata[11:0];
                tccc_pkg::REG_WIN_LOW:  lo_reg    <= pwdata[29:0];
                tccc_pkg::REG_WIN_HIGH: hi_reg    <= pwdata[29:0];
                tccc_pkg::REG_STEP:     step_reg  <= pwdata[29:0];
                tccc_pkg::REG_CENTER_A: ctr_a_reg <= pwdata[15:0];
                tccc_pkg::REG_CENTER_B: ctr_b_reg <= pwdata[15:0];
                tccc_pkg::REG_CENTER_C: ctr_c_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            tccc_pkg::REG_GAIN:     prdata = 32'(signed'(gain_reg));
            tccc_pkg::REG_LIMIT:    prdata = 32'(limit_reg);
            tccc_pkg::REG_WIN_LOW:  prdata = 32'(lo_reg);
            tccc_pkg::REG_WIN_HIGH: prdata = 32'(hi_reg);
            tccc_pkg::REG_STEP:     prdata = 32'(step_reg);
            tccc_pkg::REG_CENTER_A: prdata = 32'(signed'(ctr_a_reg));
            tccc_pkg::REG_CENTER_B: prdata = 32'(signed'(ctr_b_reg));
            tccc_pkg::REG_CENTER_C: prdata = 32'(signed'(ctr_c_reg));
            default:                prdata = '0;
        endcase
    end

    // input holding stage
    logic         hold_vld_reg;
    logic [122:0] hold_dat_reg;
    logic         hold_op_reg;
    logic         hold_take;

    tccc_pkg::top_state_t st_reg, st_next;

    assign hold_take = (st_reg == tccc_pkg::ST_IDLE) && hold_vld_reg;
    assign s_tready  = !hold_vld_reg || hold_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            hold_vld_reg <= 1'b1;
        end else if (hold_take) begin
            hold_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hold_dat_reg <= s_tdata[122:0];
            hold_op_reg  <= s_tuser[0];
        end
    end

    logic        is_sample;
    logic [31:0] wr_idx;
    assign is_sample = (hold_op_reg == tccc_pkg::OP_SAMPLE);
    assign wr_idx    = 32'(hold_dat_reg[10:0]);

    // lanes
    logic          lane_start;
    logic [2:0]    lane_done;
    logic [AW-1:0] idx_a, idx_b, idx_c;

    assign lane_start = hold_take && is_sample;

    tccc_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_a (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start),
        .width(hold_dat_reg[42:27]), .period(hold_dat_reg[58:43]),
        .cfg(dcfg), .done(lane_done[0]), .idx(idx_a)
    );
    tccc_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_b (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start),
        .width(hold_dat_reg[74:59]), .period(hold_dat_reg[90:75]),
        .cfg(dcfg), .done(lane_done[1]), .idx(idx_b)
    );
    tccc_lane #(.TABLE_DEPTH(TABLE_DEPTH)) u_lane_c (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start),
        .width(hold_dat_reg[106:91]), .period(hold_dat_reg[122:107]),
        .cfg(dcfg), .done(lane_done[2]), .idx(idx_c)
    );

    // displacement table
    logic signed [15:0] tab_mem [TABLE_DEPTH];
    logic signed [15:0] rd_q_reg;
    logic signed [15:0] tab_a_reg, tab_b_reg;
    logic [AW-1:0]      rd_addr;

    always_comb begin
        case (st_reg)
            tccc_pkg::ST_RD_B: rd_addr = idx_b;
            tccc_pkg::ST_RD_C: rd_addr = idx_c;
            default:           rd_addr = idx_a;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hold_take && !is_sample && wr_idx < 32'(TABLE_DEPTH)) begin
            tab_mem[wr_idx[AW-1:0]] <= hold_dat_reg[26:11];
        end
        rd_q_reg <= tab_mem[rd_addr];
        if (st_reg == tccc_pkg::ST_RD_B) tab_a_reg <= rd_q_reg;
        if (st_reg == tccc_pkg::ST_RD_C) tab_b_reg <= rd_q_reg;
    end

    // merge
    logic               mrg_done;
    logic signed [12:0] drv_a, drv_b, drv_c;
    logic signed [16:0] pos_a, pos_b, pos_c;

    tccc_merge u_merge (
        .aclk(aclk), .aresetn(aresetn),
        .start(st_reg == tccc_pkg::ST_MSTART),
        .tab_a(tab_a_reg), .tab_b(tab_b_reg), .tab_c(rd_q_reg),
        .center_a(ctr_a_reg), .center_b(ctr_b_reg), .center_c(ctr_c_reg),
        .gain(gain_reg), .drive_limit(limit_reg), .done(mrg_done),
        .drive_a(drv_a), .drive_b(drv_b), .drive_c(drv_c),
        .pos_a(pos_a), .pos_b(pos_b), .pos_c(pos_c)
    );

    // sequencer
    logic out_free;
    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            tccc_pkg::ST_IDLE:   if (lane_start) st_next = tccc_pkg::ST_LANE;
            tccc_pkg::ST_LANE:   if (&lane_done) st_next = tccc_pkg::ST_RD_A;
            tccc_pkg::ST_RD_A:   st_next = tccc_pkg::ST_RD_B;
            tccc_pkg::ST_RD_B:   st_next = tccc_pkg::ST_RD_C;
            tccc_pkg::ST_RD_C:   st_next = tccc_pkg::ST_MSTART;
            tccc_pkg::ST_MSTART: st_next = tccc_pkg::ST_MWAIT;
            tccc_pkg::ST_MWAIT:  if (mrg_done) st_next = tccc_pkg::ST_EMIT;
            tccc_pkg::ST_EMIT:   if (out_free) st_next = tccc_pkg::ST_IDLE;
            default:             st_next = tccc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= tccc_pkg::ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // output register
    logic        m_vld_reg;
    logic [95:0] m_dat_reg;
    logic        emit;
    assign emit = (st_reg == tccc_pkg::ST_EMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (emit) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_dat_reg <= {6'd0, pos_c, pos_b, pos_a, drv_c, drv_b, drv_a};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_dat_reg;
endmodule
`default_nettype wire

@@ rtl/tccc_lane.sv @@
// One duty channel: width*1e9/period, window clamp, (duty-low)/step, index clamp.
// Both divisions share one restoring shift-subtract loop. Depends on tccc_pkg.
`default_nettype none
module tccc_lane #(
    parameter int TABLE_DEPTH = tccc_pkg::TABLE_DEPTH
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   start,
    input  wire  [15:0]                           width,
    input  wire  [15:0]                           period,
    input  wire  tccc_pkg::duty_cfg_t             cfg,
    output logic                                  done,
    output logic [$clog2(TABLE_DEPTH)-1:0]        idx
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = tccc_pkg::PROD_W;
    localparam int DW = tccc_pkg::DUTY_W;

    tccc_pkg::lane_state_t st_reg, st_next;
    logic [5:0]    cnt_reg;
    logic [15:0]   w_reg, p_reg;
    logic [PW-1:0] dvd_reg;
    logic [DW-1:0] rem_reg, div_reg;

    logic [DW:0]   trial;
    logic          qbit;
    logic [PW-1:0] duty, d1;
    logic [DW-1:0] d2;
    logic [DW-1:0] q;

    assign trial = {rem_reg, dvd_reg[PW-1]};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_comb begin
        duty = (p_reg == 16'd0) ? PW'(cfg.lo) : dvd_reg;
        d1   = (duty < PW'(cfg.lo)) ? PW'(cfg.lo) : duty;
        d2   = (d1 > PW'(cfg.hi)) ? cfg.hi : d1[DW-1:0];
        q    = dvd_reg[DW-1:0];
        idx  = (q > DW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1) : q[AW-1:0];
        done = (st_reg == tccc_pkg::L_DONE);
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            tccc_pkg::L_IDLE, tccc_pkg::L_DONE: if (start) st_next = tccc_pkg::L_MUL;
            tccc_pkg::L_MUL:   st_next = tccc_pkg::L_DIV1;
            tccc_pkg::L_DIV1:  if (cnt_reg == 6'd1) st_next = tccc_pkg::L_CLAMP;
            tccc_pkg::L_CLAMP: st_next = tccc_pkg::L_DIV2;
            tccc_pkg::L_DIV2:  if (cnt_reg == 6'd1) st_next = tccc_pkg::L_DONE;
            default:           st_next = tccc_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= tccc_pkg::L_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            tccc_pkg::L_IDLE, tccc_pkg::L_DONE: begin
                if (start) begin
                    w_reg <= width;
                    p_reg <= period;
                end
            end
            tccc_pkg::L_MUL: begin
                dvd_reg <= PW'(w_reg) * PW'(tccc_pkg::PPB_FULL);
                rem_reg <= '0;
                div_reg <= DW'(p_reg);
                cnt_reg <= 6'(PW);
            end
            tccc_pkg::L_DIV1, tccc_pkg::L_DIV2: begin
                rem_reg <= qbit ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
                dvd_reg <= {dvd_reg[PW-2:0], qbit};
                cnt_reg <= cnt_reg - 6'd1;
            end
            tccc_pkg::L_CLAMP: begin
                // park the offset in the top bits so only DW steps are needed
                dvd_reg <= (d2 > cfg.lo) ? {d2 - cfg.lo, (PW-DW)'(0)} : '0;
                rem_reg <= '0;
                div_reg <= (cfg.step == '0) ? DW'(1) : cfg.step;
                cnt_reg <= 6'(DW);
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/tccc_merge.sv @@
// Merge stage: centred positions, cyclic differences, gain, /1000 toward zero, saturation.
// Three registered stages behind a start pulse. Depends on tccc_pkg.
`default_nettype none
module tccc_merge (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire signed [15:0] tab_a,
    input  wire signed [15:0] tab_b,
    input  wire signed [15:0] tab_c,
    input  wire signed [15:0] center_a,
    input  wire signed [15:0] center_b,
    input  wire signed [15:0] center_c,
    input  wire signed [10:0] gain,
    input  wire        [11:0] drive_limit,
    output logic              done,
    output logic signed [12:0] drive_a,
    output logic signed [12:0] drive_b,
    output logic signed [12:0] drive_c,
    output logic signed [16:0] pos_a,
    output logic signed [16:0] pos_b,
    output logic signed [16:0] pos_c
);
    logic [2:0] vld_reg;
    logic signed [16:0] pos_reg [3];
    logic signed [28:0] prod_reg [3];
    logic [43:0] scl_reg [3];
    logic        neg_reg [3];
    logic        big_reg [3];

    logic signed [17:0] diff [3];
    logic [28:0]        mag [3];
    logic [11:0]        lim;
    logic [11:0]        q [3];
    logic [11:0]        m [3];
    logic signed [12:0] drv [3];

    always_comb begin
        diff[0] = 18'(pos_reg[1]) - 18'(pos_reg[2]);
        diff[1] = 18'(pos_reg[2]) - 18'(pos_reg[0]);
        diff[2] = 18'(pos_reg[0]) - 18'(pos_reg[1]);
        lim = (drive_limit > tccc_pkg::DRIVE_CAP) ? tccc_pkg::DRIVE_CAP : drive_limit;
        for (int i = 0; i < 3; i++) begin
            mag[i] = prod_reg[i][28] ? 29'(-prod_reg[i]) : 29'(prod_reg[i]);
            q[i]   = scl_reg[i][43:tccc_pkg::RECIP_SHIFT];
            m[i]   = (big_reg[i] || q[i] > lim) ? lim : q[i];
            drv[i] = neg_reg[i] ? -13'(m[i]) : 13'(m[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            pos_reg[0] <= 17'(tab_a) - 17'(center_a);
            pos_reg[1] <= 17'(tab_b) - 17'(center_b);
            pos_reg[2] <= 17'(tab_c) - 17'(center_c);
        end
        for (int i = 0; i < 3; i++) begin
            if (vld_reg[0]) prod_reg[i] <= 29'(diff[i]) * 29'(gain);
            if (vld_reg[1]) begin
                neg_reg[i] <= prod_reg[i][28];
                big_reg[i] <= (mag[i] >= tccc_pkg::SAT_MAG);
                scl_reg[i] <= 44'(mag[i][20:0]) * 44'(tccc_pkg::GAIN_RECIP);
            end
        end
    end

    assign done    = vld_reg[2];
    assign drive_a = drv[0];
    assign drive_b = drv[1];
    assign drive_c = drv[2];
    assign pos_a   = pos_reg[0];
    assign pos_b   = pos_reg[1];
    assign pos_c   = pos_reg[2];
endmodule
`default_nettype wire

@@ rtl/tccc_checker.sv @@
// Port-level checker for the controller top level, attached by bind below.
// Depends on the top level's ports only.
`default_nettype none
module tccc_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [95:0]  m_tdata,
    input wire         pready
);
    // hold a stalled result beat
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset left a beat pending or input blocked");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("register port not ready");
endmodule

bind three_coil_odd_coupling_controller_unit tccc_checker u_tccc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
`default_nettype wire

@@ tb/tb_three_coil_odd_coupling_controller_unit.sv @@
// Self-checking bench for the three coil odd coupling controller unit.
// Loads the displacement table, sweeps register settings and checks each result beat
// against a local predictor. Depends on tccc_pkg and the unit's top level.
`timescale 1ns / 1ps

class drive_scoreboard;
    logic [95:0] pending_results[$];
    int          error_count;

    function new();
        error_count = 0;
    endfunction

    function void note_sample(logic [95:0] expected);
        pending_results.push_back(expected);
    endfunction

    function void check_result(logic [95:0] actual);
        logic [95:0] expected;
        string       field_names[6];
        int          lsb[6];
        int          wid[6];
        field_names = '{"drive_a", "drive_b", "drive_c", "position_a", "position_b", "position_c"};
        lsb = '{0, 13, 26, 39, 56, 73};
        wid = '{13, 13, 13, 17, 17, 17};
        if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: %h", actual);
            error_count++;
            return;
        end
        expected = pending_results.pop_front();
        for (int f = 0; f < 6; f++) begin
            if (((expected >> lsb[f]) & ((96'd1 << wid[f]) - 1)) !==
                ((actual >> lsb[f]) & ((96'd1 << wid[f]) - 1))) begin
                $error("%s: expected %h, got %h", field_names[f],
                       (expected >> lsb[f]) & ((96'd1 << wid[f]) - 1),
                       (actual >> lsb[f]) & ((96'd1 << wid[f]) - 1));
                error_count++;
            end
        end
    endfunction
endclass

module tb_three_coil_odd_coupling_controller_unit;

    localparam int STALL_LIMIT = 20000;
    localparam int TABLE_DEPTH = tccc_pkg::TABLE_DEPTH;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    three_coil_odd_coupling_controller_unit DUT (.*);

    // predictor state
    logic signed [15:0] disp_table[TABLE_DEPTH];
    bit                 entry_written[TABLE_DEPTH];
    logic signed [10:0] gain_q;
    logic [11:0]        limit_q;
    logic [29:0]        win_low_q;
    logic [29:0]        win_high_q;
    logic [29:0]        step_q;
    logic signed [15:0] center_q[3];

    drive_scoreboard board;
    bit              sending_done;
    int              idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned table_slot(logic [15:0] w, logic [15:0] p);
        longint unsigned duty;
        longint unsigned idx;
        longint unsigned stp;
        stp = (step_q == 0) ? 1 : step_q;
        duty = (p == 0) ? win_low_q : (longint'(w) * 64'd1000000000) / p;
        if (duty < win_low_q) duty = win_low_q;
        if (duty > win_high_q) duty = win_high_q;
        idx = (duty > win_low_q) ? (duty - win_low_q) / stp : 0;
        if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
        return int'(idx);
    endfunction

    function automatic logic [12:0] coil_drive(longint diff);
        longint lim;
        longint d;
        lim = (limit_q > 2048) ? 2048 : limit_q;
        d = (diff * longint'(gain_q)) / 1000;
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return d[12:0];
    endfunction

    function automatic logic [95:0] coupling_result(logic [127:0] d);
        longint pos[3];
        logic [95:0] r;
        for (int c = 0; c < 3; c++)
            pos[c] = longint'(disp_table[table_slot(d[27 + 32*c +: 16], d[43 + 32*c +: 16])])
                     - longint'(center_q[c]);
        r = '0;
        r[12:0]  = coil_drive(pos[1] - pos[2]);
        r[25:13] = coil_drive(pos[2] - pos[0]);
        r[38:26] = coil_drive(pos[0] - pos[1]);
        r[55:39] = pos[0][16:0];
        r[72:56] = pos[1][16:0];
        r[89:73] = pos[2][16:0];
        return r;
    endfunction

    function automatic int short_or_long_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    task automatic write_reg(tccc_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            tccc_pkg::REG_GAIN:     gain_q = value[10:0];
            tccc_pkg::REG_LIMIT:    limit_q = value[11:0];
            tccc_pkg::REG_WIN_LOW:  win_low_q = value[29:0];
            tccc_pkg::REG_WIN_HIGH: win_high_q = value[29:0];
            tccc_pkg::REG_STEP:     step_q = value[29:0];
            tccc_pkg::REG_CENTER_A: center_q[0] = value[15:0];
            tccc_pkg::REG_CENTER_B: center_q[1] = value[15:0];
            tccc_pkg::REG_CENTER_C: center_q[2] = value[15:0];
            default: ;
        endcase
    endtask

    // Hold the beat until accepted; the predictor runs at acceptance time.
    // tvalid stays high after acceptance so back-to-back beats need no second
    // assignment in the same step; gaps and drains drop it.
    task automatic send_beat(tccc_pkg::op_code_t op, logic [127:0] data);
        int gap;
        gap = (sending_done) ? 0 : short_or_long_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == tccc_pkg::OP_SAMPLE) begin
            board.note_sample(coupling_result(data));
        end else if (data[10:0] < TABLE_DEPTH) begin
            disp_table[data[10:0]] = data[26:11];
            entry_written[data[10:0]] = 1'b1;
        end
    endtask

    task automatic load_entry(int idx, logic [15:0] value);
        logic [127:0] d;
        d = {$urandom, $urandom, $urandom, $urandom};
        d[10:0]  = idx[10:0];
        d[26:11] = value;
        send_beat(tccc_pkg::OP_TABLE_WRITE, d);
    endtask

    // a channel that would land on an unwritten entry falls back to a zero
    // period, which always reads entry 0
    task automatic send_sample(logic [15:0] w[3], logic [15:0] p[3]);
        logic [127:0] d;
        logic [15:0]  pp[3];
        d = {$urandom, $urandom, $urandom, $urandom};
        for (int c = 0; c < 3; c++) begin
            pp[c] = p[c];
            if (!entry_written[table_slot(w[c], p[c])]) pp[c] = 16'd0;
            d[27 + 32*c +: 16] = w[c];
            d[43 + 32*c +: 16] = pp[c];
        end
        send_beat(tccc_pkg::OP_SAMPLE, d);
    endtask

    function automatic logic [15:0] rand_width();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [15:0] rand_period();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return $urandom_range(1, 8);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic random_sample();
        logic [15:0] w[3];
        logic [15:0] p[3];
        for (int c = 0; c < 3; c++) begin
            p[c] = rand_period();
            // mostly keep duty in a lively range so table entries spread
            if ($urandom_range(0, 3) != 0 && p[c] != 0) w[c] = $urandom_range(0, p[c]);
            else w[c] = rand_width();
        end
        send_sample(w, p);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_settings();
        write_reg(tccc_pkg::REG_GAIN, $urandom_range(0, 2047));
        write_reg(tccc_pkg::REG_LIMIT,
                  ($urandom_range(0, 3) == 0) ? 32'hFFF : $urandom_range(0, 2048));
        write_reg(tccc_pkg::REG_WIN_LOW, $urandom_range(0, 600000000));
        write_reg(tccc_pkg::REG_WIN_HIGH,
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 200000000)
                                              : $urandom_range(300000000, 1000000000));
        case ($urandom_range(0, 3))
            0: write_reg(tccc_pkg::REG_STEP, 0);
            1: write_reg(tccc_pkg::REG_STEP, $urandom_range(1, 1000));
            2: write_reg(tccc_pkg::REG_STEP, $urandom_range(1, 1000000000));
            default: write_reg(tccc_pkg::REG_STEP, $urandom_range(100000, 600000));
        endcase
        write_reg(tccc_pkg::REG_CENTER_A, $urandom);
        write_reg(tccc_pkg::REG_CENTER_B, $urandom);
        write_reg(tccc_pkg::REG_CENTER_C, $urandom);
    endtask

    // result side: random stalls, check on each beat
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            int gap;
            gap = short_or_long_gap();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (m_tvalid) board.check_result(m_tdata);
        end
    end

    // watchdog: cycles with no accepted beat on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_three_coil_odd_coupling_controller_unit: done, errors");
            $finish;
        end
    end

    initial begin
        logic [15:0] w[3];
        logic [15:0] p[3];
        board = new();
        sending_done = 1'b0;
        idle_cycles = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        gain_q = 0;
        limit_q = 1843;
        win_low_q = 170000000;
        win_high_q = 470000000;
        step_q = 146484;
        center_q = '{0, 0, 0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // both ends and a spread of entries; entry 0 backs the zero-period fallback
        load_entry(0, 16'h8000);
        load_entry(TABLE_DEPTH - 1, 16'h7FFF);
        load_entry(1, 16'h7FFF);
        for (int i = 0; i < 60; i++) load_entry($urandom_range(2, TABLE_DEPTH - 2), $urandom);

        // directed: reset settings, then extremes
        w = '{16'd0, 16'hFFFF, 16'd1000}; p = '{16'd0, 16'hFFFF, 16'd3000};
        send_sample(w, p);
        wait_drained();
        write_reg(tccc_pkg::REG_GAIN, 11'h3FF);
        write_reg(tccc_pkg::REG_LIMIT, 32'hFFF);
        write_reg(tccc_pkg::REG_WIN_LOW, 0);
        write_reg(tccc_pkg::REG_WIN_HIGH, 1000000000);
        write_reg(tccc_pkg::REG_STEP, 0);
        write_reg(tccc_pkg::REG_CENTER_A, 16'h7FFF);
        write_reg(tccc_pkg::REG_CENTER_B, 16'h8000);
        write_reg(tccc_pkg::REG_CENTER_C, 0);
        w = '{16'd0, 16'd0, 16'd1}; p = '{16'd1, 16'hFFFF, 16'd0};
        send_sample(w, p);
        w = '{16'hFFFF, 16'd1, 16'hFFFF}; p = '{16'd1, 16'hFFFF, 16'hFFFF};
        send_sample(w, p);
        wait_drained();
        write_reg(tccc_pkg::REG_GAIN, 11'h400);
        write_reg(tccc_pkg::REG_LIMIT, 0);
        write_reg(tccc_pkg::REG_WIN_LOW, 1000000000);
        write_reg(tccc_pkg::REG_WIN_HIGH, 0);
        write_reg(tccc_pkg::REG_STEP, 1000000000);
        write_reg(tccc_pkg::REG_CENTER_A, 16'h8000);
        write_reg(tccc_pkg::REG_CENTER_B, 16'h7FFF);
        write_reg(tccc_pkg::REG_CENTER_C, 16'hFFFF);
        w = '{16'd5, 16'd0, 16'hFFFF}; p = '{16'd7, 16'd0, 16'd2};
        send_sample(w, p);
        wait_drained();
        write_reg(tccc_pkg::REG_WIN_LOW, 100000000);
        write_reg(tccc_pkg::REG_WIN_HIGH, 900000000);
        write_reg(tccc_pkg::REG_STEP, 1);
        write_reg(tccc_pkg::REG_LIMIT, 2048);
        w = '{16'd1, 16'd2, 16'd3}; p = '{16'd3, 16'd3, 16'd3};
        send_sample(w, p);
        load_entry(2047 + 0, 16'h1234);
        send_sample(w, p);
        wait_drained();

        for (int phase = 0; phase < 10; phase++) begin
            random_settings();
            for (int k = 0; k < 43; k++) begin
                if ($urandom_range(0, 9) == 0) load_entry($urandom_range(0, TABLE_DEPTH - 1),
                                                          $urandom);
                else random_sample();
            end
            wait_drained();
        end

        sending_done = 1'b1;
        wait_drained();
        if (board.error_count == 0 && board.pending_results.size() == 0)
            $display("tb_three_coil_odd_coupling_controller_unit: done, clean");
        else
            $display("tb_three_coil_odd_coupling_controller_unit: done, errors");
        $finish;
    end
endmodule
